// File: sv/interval_average_of_tabulated_profile_core_macros.svh
// Assertion macros for the interval average core.
`ifndef INTERVAL_AVERAGE_OF_TABULATED_PROFILE_CORE_MACROS_SVH
`define INTERVAL_AVERAGE_OF_TABULATED_PROFILE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define IATP_CHECK(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define IATP_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define IATP_CHECK(lbl, clk, rst_n, ante, cons)
`define IATP_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/iatp_pkg.sv
// Shared types and constants of the interval average core.
`timescale 1ns / 1ps
package iatp_pkg;
    localparam int IN_W  = 200;
    localparam int OUT_W = 96;
    localparam int ACC_W = 80;
    localparam int DIV_W = 34;
    localparam int PIN_W = 7;

    localparam logic [PIN_W-1:0] PIN_RESET = 7'd2;
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_QUERY   = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic [2:0][31:0] coef;
        logic [31:0]      height;
    } entry_t;

    typedef struct packed {
        logic        pair;
        logic        ui;
        logic        vi;
        logic [31:0] up;
        logic [31:0] vp;
        logic [31:0] q;
        logic        wneg;
        logic [31:0] wmag;
    } piece_t;

    typedef struct packed {
        logic [DIV_W-1:0] quo;
        logic             rem_nz;
        logic             ovf;
    } div_res_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_FIRST, ST_FETCH, ST_WAITN, ST_EVAL, ST_PSEL, ST_END, ST_EMUL,
        ST_DSTART, ST_DWAIT, ST_SUM, ST_WMUL, ST_ACC, ST_ADV, ST_FDIV, ST_FWAIT,
        ST_DONE
    } state_t;

    function automatic logic [32:0] sdiff(logic [31:0] a, logic [31:0] b);
        return {a[31], a} - {b[31], b};
    endfunction
endpackage

// File: sv/iatp_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module iatp_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/iatp_div.sv
// Restoring divider, one quotient bit per cycle, with overflow precheck.
`timescale 1ns / 1ps
module iatp_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [iatp_pkg::ACC_W-1:0]    num,
    input  logic [iatp_pkg::DIV_W-1:0]    den,
    output logic                          busy,
    output logic                          done,
    output iatp_pkg::div_res_t            res
);
    import iatp_pkg::*;
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] rem_reg, lo_reg, den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg, ovf_reg;
    logic [DIV_W:0]   trial, diff;
    logic             ge;

    assign trial = {rem_reg, lo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // quotient fits DIV_W bits unless the high part already reaches den
            ovf_reg <= num[ACC_W-1:DIV_W] >= (ACC_W-DIV_W)'(den);
            rem_reg <= num[2*DIV_W-1:DIV_W];
            lo_reg  <= num[DIV_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            lo_reg  <= {lo_reg[DIV_W-2:0], ge};
        end
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign res.quo    = lo_reg;
    assign res.rem_nz = |rem_reg;
    assign res.ovf    = ovf_reg;
endmodule

// File: sv/interval_average_of_tabulated_profile_core.sv
// Top level: profile table load and trapezoid interval average queries.
//
// Channel  Dir  Fields (lowest bit up)
// s_*      in   tdata: point_index, point_height, coeff a/b/c, cell_low, cell_high; tuser: mode
// m_*      out  tdata: average_a, average_b, average_c; tuser: query_status
// cfg_*    in   cfg_data: points_in_use
//
// A query reads the first point, then per point fetches the next (none for the last one),
// picks its trapezoid pieces and advances. Each piece takes the three coefficients in turn:
// two endpoints, a sum, a width multiply and an accumulate. An endpoint taken as is needs no
// division, an interpolated one a multiply and a divider run. Three final divisions follow;
// an empty interval goes straight to DONE. Reset does not clear the table. A finished result
// waits in the output register while the next item is accepted; a second waits for m_tready.
`timescale 1ns / 1ps
`include "interval_average_of_tabulated_profile_core_macros.svh"
module interval_average_of_tabulated_profile_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // point_index[5:0], point_height, point_coeff_a, point_coeff_b, point_coeff_c,
    // cell_low, cell_high, zero fill
    input  logic [iatp_pkg::IN_W-1:0]  s_tdata,
    input  logic [0:0]                 s_tuser,   // mode
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [iatp_pkg::OUT_W-1:0] m_tdata,   // average_a, average_b, average_c
    output logic [0:0]                 m_tuser,   // query_status
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [iatp_pkg::PIN_W-1:0] cfg_data   // points_in_use
);
    import iatp_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = (CW > PIN_W) ? CW : PIN_W;

    state_t state_reg, state_next;

    logic [PIN_W-1:0] pin_reg;
    logic [NW-1:0]    n_reg, i_reg, i_inc, pin_ext, idx_ext, n_calc;
    logic [31:0]      yl_reg, yu_reg;
    logic [DIV_W-1:0] d_reg;
    entry_t           prev_reg, cur_reg, next_reg, rdata;
    piece_t           piece_reg, pend1_reg, pend2_reg, p1, p2;
    logic             pend1_v_reg, pend2_v_reg, p1_v, p2_v;
    logic [1:0]       k_reg;
    logic             e_reg;
    logic [31:0]      u_reg, v_reg;
    logic [32:0]      s_mag_reg;
    logic             prod_neg_reg;
    logic [64:0]      mul_reg;
    logic [ACC_W-1:0] acc_reg [3];
    logic [31:0]      avg_reg [3];
    logic             status_reg;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_user_reg;

    logic             in_acc, is_query, bad_iv, out_free, we;
    logic [AW-1:0]    raddr;
    logic [32:0]      iv_len;

    // input fields
    logic [5:0]  f_idx;
    logic [31:0] f_h, f_a, f_b, f_c, f_lo, f_hi;
    assign f_idx = s_tdata[5:0];
    assign f_h   = s_tdata[37:6];
    assign f_a   = s_tdata[69:38];
    assign f_b   = s_tdata[101:70];
    assign f_c   = s_tdata[133:102];
    assign f_lo  = s_tdata[165:134];
    assign f_hi  = s_tdata[197:166];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign is_query  = (s_tuser[0] == MODE_QUERY);
    assign bad_iv    = !($signed(f_hi) > $signed(f_lo));
    assign iv_len    = sdiff(f_hi, f_lo);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign pin_ext = NW'(pin_reg);
    assign idx_ext = NW'(f_idx);
    assign n_calc  = (pin_ext < NW'(2)) ? NW'(2) :
                     (pin_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : pin_ext;
    assign i_inc   = i_reg + 1'b1;

    // table memory
    entry_t wentry;
    assign wentry.height = f_h;
    assign wentry.coef   = {f_c, f_b, f_a};
    assign we = in_acc && !is_query && (idx_ext < NW'(TABLE_DEPTH));

    iatp_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (AW'(idx_ext)),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (rdata)
    );

    // piece selection for the current point
    logic [31:0] h, hp, hn;
    logic        in_span, has_prev, has_next;
    logic [32:0] d_h_hp, d_h_yl, d_yl_hp, d_yu_hp, d_yu_h, d_hn_h, d_yu_yl;
    assign h        = cur_reg.height;
    assign hp       = prev_reg.height;
    assign hn       = next_reg.height;
    assign in_span  = ($signed(h) > $signed(yl_reg)) && ($signed(h) < $signed(yu_reg));
    assign has_prev = (i_reg != '0);
    assign has_next = (i_inc < n_reg);
    assign d_h_hp   = sdiff(h, hp);
    assign d_h_yl   = sdiff(h, yl_reg);
    assign d_yl_hp  = sdiff(yl_reg, hp);
    assign d_yu_hp  = sdiff(yu_reg, hp);
    assign d_yu_h   = sdiff(yu_reg, h);
    assign d_hn_h   = sdiff(hn, h);
    assign d_yu_yl  = sdiff(yu_reg, yl_reg);

    always_comb
    begin
        p1   = '0;
        p2   = '0;
        p1_v = 1'b0;
        p2_v = 1'b0;
        if (in_span && has_prev)
        begin
            p1_v = 1'b1;
            if ($signed(hp) <= $signed(yl_reg))
            begin
                p1.ui   = 1'b1;
                p1.up   = d_yl_hp[31:0];
                p1.q    = d_h_hp[31:0];
                p1.wmag = d_h_yl[31:0];
            end
            else
            begin
                // full segment, negative width when the table is unsorted
                p1.wneg = d_h_hp[32];
                p1.wmag = d_h_hp[32] ? 32'(33'd0 - d_h_hp) : d_h_hp[31:0];
            end
        end
        else if (!in_span && has_prev && ($signed(h) >= $signed(yu_reg))
                 && ($signed(hp) <= $signed(yl_reg)))
        begin
            p1_v    = 1'b1;
            p1.ui   = 1'b1;
            p1.vi   = 1'b1;
            p1.up   = d_yl_hp[31:0];
            p1.vp   = d_yu_hp[31:0];
            p1.q    = d_h_hp[31:0];
            p1.wmag = d_yu_yl[31:0];
        end
        if (in_span && has_next && ($signed(hn) >= $signed(yu_reg)))
        begin
            p2_v    = 1'b1;
            p2.pair = 1'b1;
            p2.vi   = 1'b1;
            p2.vp   = d_yu_h[31:0];
            p2.q    = d_hn_h[31:0];
            p2.wmag = d_yu_h[31:0];
        end
    end

    // endpoint datapath
    logic [31:0] c0, c1, pe, raw, ival;
    logic [32:0] x, xabs, s33;
    logic [35:0] c0x, adj36, ival36, negv36;
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    div_res_t    dres;
    logic        div_start, div_busy, div_done;
    logic [ACC_W-1:0] div_num, acc_k, acc_abs, addend;
    logic [DIV_W-1:0] div_den;
    logic [31:0] avg_val;

    assign c0     = piece_reg.pair ? cur_reg.coef[k_reg]  : prev_reg.coef[k_reg];
    assign c1     = piece_reg.pair ? next_reg.coef[k_reg] : cur_reg.coef[k_reg];
    assign x      = sdiff(c1, c0);
    assign xabs   = x[32] ? (33'd0 - x) : x;
    assign pe     = e_reg ? piece_reg.vp : piece_reg.up;
    assign raw    = e_reg ? c1 : c0;
    assign c0x    = {{4{c0[31]}}, c0};
    assign adj36  = {2'b00, dres.quo} + 36'(dres.rem_nz);
    assign ival36 = x[32] ? (c0x - adj36) : (c0x + {2'b00, dres.quo});
    assign ival   = ival36[31:0];
    assign s33    = {u_reg[31], u_reg} + {v_reg[31], v_reg};
    assign negv36 = 36'd0 - adj36;

    assign mul_a = (state_reg == ST_WMUL) ? s_mag_reg : xabs;
    assign mul_b = (state_reg == ST_WMUL) ? piece_reg.wmag : pe;

    assign acc_k   = acc_reg[k_reg];
    assign acc_abs = acc_k[ACC_W-1] ? (ACC_W'(0) - acc_k) : acc_k;
    assign addend  = ACC_W'(mul_reg);

    always_comb
    begin
        if (acc_k[ACC_W-1])
        begin
            avg_val = (dres.ovf || (adj36 > 36'h0_8000_0000)) ? 32'h8000_0000
                                                              : negv36[31:0];
        end
        else
        begin
            avg_val = (dres.ovf || (dres.quo > DIV_W'(32'h7FFF_FFFF))) ? 32'h7FFF_FFFF
                                                                       : dres.quo[31:0];
        end
    end

    iatp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .res   (dres)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_acc && is_query) state_next = bad_iv ? ST_DONE : ST_FIRST;
            ST_FIRST:  state_next = ST_FETCH;
            ST_FETCH:  state_next = has_next ? ST_WAITN : ST_EVAL;
            ST_WAITN:  state_next = ST_EVAL;
            ST_EVAL:   state_next = ST_PSEL;
            ST_PSEL:   state_next = (pend1_v_reg || pend2_v_reg) ? ST_END : ST_ADV;
            ST_END:
            begin
                if (e_reg ? piece_reg.vi : piece_reg.ui) state_next = ST_EMUL;
                else if (e_reg)                          state_next = ST_SUM;
            end
            ST_EMUL:   state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT:  if (div_done) state_next = e_reg ? ST_SUM : ST_END;
            ST_SUM:    state_next = ST_WMUL;
            ST_WMUL:   state_next = ST_ACC;
            ST_ACC:    state_next = (k_reg == 2'd2) ? ST_PSEL : ST_END;
            ST_ADV:    state_next = has_next ? ST_FETCH : ST_FDIV;
            ST_FDIV:   state_next = ST_FWAIT;
            ST_FWAIT:  if (div_done) state_next = (k_reg == 2'd2) ? ST_DONE : ST_FDIV;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        raddr     = '0;
        div_start = 1'b0;
        div_num   = ACC_W'(mul_reg);
        div_den   = DIV_W'(piece_reg.q);
        unique case (state_reg)
            ST_FETCH:  raddr = AW'(i_inc);
            ST_DSTART: div_start = 1'b1;
            ST_FDIV:
            begin
                div_start = 1'b1;
                div_num   = acc_abs;
                div_den   = d_reg;
            end
            default:   raddr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pin_reg      <= PIN_RESET;
            m_tvalid_reg <= 1'b0;
            pend1_v_reg  <= 1'b0;
            pend2_v_reg  <= 1'b0;
            k_reg        <= '0;
            e_reg        <= 1'b0;
            i_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                pin_reg <= cfg_data;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_FIRST: i_reg <= '0;
                ST_EVAL:
                begin
                    pend1_v_reg <= p1_v;
                    pend2_v_reg <= p2_v;
                end
                ST_PSEL:
                begin
                    k_reg <= '0;
                    e_reg <= 1'b0;
                    if (pend1_v_reg)      pend1_v_reg <= 1'b0;
                    else if (pend2_v_reg) pend2_v_reg <= 1'b0;
                end
                ST_END:   if (!(e_reg ? piece_reg.vi : piece_reg.ui)) e_reg <= 1'b1;
                ST_DWAIT: if (div_done) e_reg <= 1'b1;
                ST_ACC:
                begin
                    e_reg <= 1'b0;
                    if (k_reg != 2'd2) k_reg <= k_reg + 1'b1;
                end
                ST_ADV:
                begin
                    k_reg <= '0;
                    if (has_next) i_reg <= i_inc;
                end
                ST_FWAIT: if (div_done && k_reg != 2'd2) k_reg <= k_reg + 1'b1;
                default:  ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && is_query)
                begin
                    yl_reg <= f_lo;
                    yu_reg <= f_hi;
                    n_reg  <= n_calc;
                    d_reg  <= {iv_len, 1'b0};
                    for (int j = 0; j < 3; j++)
                    begin
                        acc_reg[j] <= '0;
                        avg_reg[j] <= '0;
                    end
                    status_reg <= bad_iv ? STATUS_EMPTY : STATUS_OK;
                end
            end
            ST_FIRST: cur_reg <= rdata;
            ST_WAITN: next_reg <= rdata;
            ST_EVAL:
            begin
                pend1_reg <= p1;
                pend2_reg <= p2;
            end
            ST_PSEL:  piece_reg <= pend1_v_reg ? pend1_reg : pend2_reg;
            ST_END:
            begin
                if (!(e_reg ? piece_reg.vi : piece_reg.ui))
                begin
                    if (e_reg) v_reg <= raw;
                    else       u_reg <= raw;
                end
            end
            ST_EMUL:  mul_reg <= 65'(mul_a) * 65'(mul_b);
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    if (e_reg) v_reg <= ival;
                    else       u_reg <= ival;
                end
            end
            ST_SUM:
            begin
                s_mag_reg    <= s33[32] ? (33'd0 - s33) : s33;
                prod_neg_reg <= s33[32] ^ piece_reg.wneg;
            end
            ST_WMUL:  mul_reg <= 65'(mul_a) * 65'(mul_b);
            ST_ACC:   acc_reg[k_reg] <= prod_neg_reg ? (acc_k - addend) : (acc_k + addend);
            ST_ADV:
            begin
                // slide the window by one point
                prev_reg <= cur_reg;
                cur_reg  <= next_reg;
            end
            ST_FWAIT: if (div_done) avg_reg[k_reg] <= avg_val;
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg <= {avg_reg[2], avg_reg[1], avg_reg[0]};
                    out_user_reg <= status_reg;
                end
            end
            default:  ;
        endcase
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;

    `IATP_CHECK(a_div_free, clk, rst_n, div_start, !div_busy)
    `IATP_CHECK(a_empty_zero, clk, rst_n, m_tvalid && m_tuser[0], m_tdata == '0)
    `IATP_NEXT(a_result_shown, clk, rst_n, (state_reg == ST_DONE) && out_free, m_tvalid)
    `IATP_CHECK(a_accept_idle_div, clk, rst_n, s_tvalid && s_tready, !div_busy)
endmodule

// File: dv/interval_average_of_tabulated_profile_core_tb.sv
// Testbench for the interval average core: table loads, interval queries, point-count settings.
`timescale 1ns / 1ps
module interval_average_of_tabulated_profile_core_tb;
    import iatp_pkg::*;

    localparam int DEPTH      = 64;
    localparam int STALL_MAX  = 200000;
    localparam int SETTLE     = 80;
    localparam int ITEM_GOAL  = 1200;
    localparam logic signed [31:0] SMAX = 32'sh7fffffff;
    localparam logic signed [31:0] SMIN = 32'sh80000000;

    typedef struct packed {
        logic               mode;
        logic [5:0]         slot;
        logic signed [31:0] height;
        logic signed [31:0] ca;
        logic signed [31:0] cb;
        logic signed [31:0] cc;
        logic signed [31:0] low;
        logic signed [31:0] high;
    } item_t;

    typedef struct packed {
        logic [2:0][31:0] avg;
        logic             status;
    } average_t;

    typedef struct packed {
        item_t    it;
        logic     typed;
        average_t want;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [PIN_W-1:0]     cfg_data = PIN_RESET;

    // predictor state
    longint    height_tab [DEPTH];
    longint    coeff_tab  [3][DEPTH];
    int        points_cfg;
    longint    sum_hi [3];
    longint    sum_lo [3];
    average_t  averages_due [$];

    int        mismatches = 0;
    int        n_loads = 0;
    int        n_queries = 0;
    int        n_empty = 0;
    int        n_cfg = 0;
    int        n_results = 0;
    int        n_sent = 0;
    bit        held_off = 1'b0;

    interval_average_of_tabulated_profile_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic longint floor_quot(longint n, longint d, output longint r);
        longint q;
        q = n / d;
        r = n % d;
        if (r < 0)
        begin
            r = r + d;
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint split_quot(longint hi, longint lo, longint d);
        longint ra, rb, qa, qt;
        qa = floor_quot(hi, d, ra);
        if (qa > (64'sd1 <<< 40)) qa = 64'sd1 <<< 40;
        if (qa < -(64'sd1 <<< 40)) qa = -(64'sd1 <<< 40);
        qt = floor_quot(ra * 65536 + lo, d, rb);
        return qa * 65536 + qt;
    endfunction

    function automatic longint lerp(longint c0, longint c1, longint p, longint q);
        longint x;
        x = c1 - c0;
        return c0 + split_quot(x * (p >>> 16), x * (p & 64'hffff), q);
    endfunction

    // accumulate w*(u+v) for one trapezoid piece, between slots j0 and j1
    function automatic void add_trapezoid(longint w, int j0, int j1, longint p0, longint p1,
                                          longint q, bit lerp_u, bit lerp_v);
        longint u, v, s, wm;
        bit neg;
        neg = w < 0;
        wm = neg ? -w : w;
        for (int k = 0; k < 3; k++)
        begin
            u = lerp_u ? lerp(coeff_tab[k][j0], coeff_tab[k][j1], p0, q) : coeff_tab[k][j0];
            v = lerp_v ? lerp(coeff_tab[k][j0], coeff_tab[k][j1], p1, q) : coeff_tab[k][j1];
            s = neg ? -(u + v) : (u + v);
            sum_hi[k] += s * (wm >>> 16);
            sum_lo[k] += s * (wm & 64'hffff);
        end
    endfunction

    function automatic average_t interval_average(longint yl, longint yu);
        average_t r;
        int n;
        longint h, hp, hn, a;
        r = '0;
        if (yu <= yl)
        begin
            r.status = STATUS_EMPTY;
            return r;
        end
        n = points_cfg < 2 ? 2 : (points_cfg > DEPTH ? DEPTH : points_cfg);
        for (int k = 0; k < 3; k++)
        begin
            sum_hi[k] = 0;
            sum_lo[k] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            h = height_tab[i];
            if (h > yl && h < yu)
            begin
                if (i > 0)
                begin
                    hp = height_tab[i-1];
                    if (hp <= yl)
                        add_trapezoid(h - yl, i-1, i, yl - hp, 0, h - hp, 1'b1, 1'b0);
                    else
                        add_trapezoid(h - hp, i-1, i, 0, 0, 1, 1'b0, 1'b0);
                end
                if (i + 1 < n && height_tab[i+1] >= yu)
                begin
                    hn = height_tab[i+1];
                    add_trapezoid(yu - h, i, i+1, 0, yu - h, hn - h, 1'b0, 1'b1);
                end
            end
            else if (i > 0 && h >= yu && height_tab[i-1] <= yl)
            begin
                hp = height_tab[i-1];
                add_trapezoid(yu - yl, i-1, i, yl - hp, yu - hp, h - hp, 1'b1, 1'b1);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            a = split_quot(sum_hi[k], sum_lo[k], 2 * (yu - yl));
            if (a > SMAX) a = SMAX;
            if (a < SMIN) a = SMIN;
            r.avg[k] = a[31:0];
        end
        r.status = STATUS_OK;
        return r;
    endfunction

    task automatic send_item(item_t it, bit typed, average_t want);
        int gap;
        gap = 0;
        if (!(n_sent >= 500 && n_sent < 700) && $urandom_range(99) < 20)
            gap = $urandom_range(6, 1);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {2'b00, it.high, it.low, it.cc, it.cb, it.ca, it.height, it.slot};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_sent++;
        if (it.mode == MODE_LOAD)
        begin
            height_tab[it.slot]   = it.height;
            coeff_tab[0][it.slot] = it.ca;
            coeff_tab[1][it.slot] = it.cb;
            coeff_tab[2][it.slot] = it.cc;
            n_loads++;
        end
        else
        begin
            n_queries++;
            if (it.high <= it.low) n_empty++;
            averages_due.push_back(typed ? want : interval_average(it.low, it.high));
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (averages_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_points(int v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v[PIN_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid  <= 1'b0;
        points_cfg = v;
        n_cfg++;
    endtask

    function automatic item_t load_item(int slot, longint h, longint a, longint b, longint c);
        item_t it;
        it = '0;
        it.mode = MODE_LOAD;
        it.slot = slot[5:0];
        it.height = h[31:0];
        it.ca = a[31:0];
        it.cb = b[31:0];
        it.cc = c[31:0];
        return it;
    endfunction

    function automatic item_t query_item(longint lo, longint hi);
        item_t it;
        it = '0;
        it.mode = MODE_QUERY;
        it.low = lo[31:0];
        it.high = hi[31:0];
        it.slot = 6'($urandom);
        it.height = $urandom;
        it.ca = $urandom;
        it.cb = $urandom;
        it.cc = $urandom;
        return it;
    endfunction

    function automatic row_t row(item_t it, bit typed, average_t want);
        row_t r;
        r.it = it;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic longint clamp32(longint v);
        return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
    endfunction

    // write a sorted profile into slots 0..n-1
    task automatic load_profile(int n);
        longint hs [DEPTH];
        longint t, step;
        bit wide_span;
        wide_span = $urandom_range(3) == 0;
        hs[0] = $signed($urandom);
        step = 64'sd1 <<< $urandom_range(22, 4);
        for (int i = 1; i < n; i++)
            hs[i] = wide_span ? longint'($signed($urandom))
                              : clamp32(hs[i-1] + $urandom_range(step, 0));
        if (wide_span)
            for (int i = 1; i < n; i++)
                for (int j = i; j > 0 && hs[j-1] > hs[j]; j--)
                begin
                    t = hs[j];
                    hs[j] = hs[j-1];
                    hs[j-1] = t;
                end
        for (int i = 0; i < n; i++)
            send_item(load_item(i, hs[i], $signed($urandom), $signed($urandom),
                                $signed($urandom)), 1'b0, '0);
    endtask

    function automatic longint near_point(int n);
        longint p;
        p = height_tab[$urandom_range(n - 1)];
        case ($urandom_range(3))
            0: return p;
            1: return clamp32(p + $signed($urandom_range(512)) - 256);
            2: return clamp32(p + ($signed($urandom) >>> $urandom_range(20, 4)));
            default: return longint'($signed($urandom));
        endcase
    endfunction

    // results
    initial
    begin : receiver
        int hold;
        average_t e;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (averages_due.size() == 0)
                begin
                    $error("result with no query pending: %h status %0d", m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    e = averages_due.pop_front();
                    for (int k = 0; k < 3; k++)
                        if (m_tdata[32*k +: 32] !== e.avg[k])
                        begin
                            $error("average_%s: expected %h, got %h", k == 0 ? "a" :
                                   (k == 1 ? "b" : "c"), e.avg[k], m_tdata[32*k +: 32]);
                            mismatches++;
                        end
                    if (m_tuser[0] !== e.status)
                    begin
                        $error("query_status: expected %0d, got %0d", e.status, m_tuser[0]);
                        mismatches++;
                    end
                end
            end
            if (!held_off && n_results == 100)
            begin
                held_off = 1'b1;
                hold = 3000;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (n_results >= 150 && n_results < 250)
                m_tready <= 1'b1;
            else
                m_tready <= $urandom_range(99) >= 20;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_MAX)
            begin
                $display("timeout: no handshake for %0d cycles", quiet);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        row_t dir [$];
        average_t none, empty;
        int pick_list [6];
        int n, neff, ops, phase;
        longint lo, hi;

        none = '0;
        empty = '0;
        empty.status = STATUS_EMPTY;
        pick_list = '{0, 1, 2, 64, 65, 127};
        points_cfg = PIN_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            height_tab[i] = 0;
            for (int k = 0; k < 3; k++) coeff_tab[k][i] = 0;
        end

        dir.push_back(row(query_item(0, 0), 1'b1, empty));
        dir.push_back(row(query_item(SMAX, SMIN), 1'b1, empty));
        dir.push_back(row(query_item(5, 4), 1'b1, empty));
        dir.push_back(row(load_item(0, SMIN, SMAX, SMIN, 0), 1'b0, none));
        dir.push_back(row(load_item(1, SMAX, SMIN, SMAX, -1), 1'b0, none));
        dir.push_back(row(query_item(SMIN, SMAX), 1'b0, none));
        dir.push_back(row(query_item(-65536, 65536), 1'b0, none));
        dir.push_back(row(query_item(SMIN, SMIN + 1), 1'b0, none));
        dir.push_back(row(query_item(SMAX - 1, SMAX), 1'b0, none));
        dir.push_back(row(load_item(63, -1, -1, -1, -1), 1'b0, none));
        dir.push_back(row(load_item(0, 0, 32'h10000, -32'sh10000, 32'h7fff0000), 1'b0, none));
        dir.push_back(row(load_item(1, 32'h100000, 32'h30000, 0, SMIN), 1'b0, none));
        dir.push_back(row(query_item(0, 32'h100000), 1'b0, none));
        dir.push_back(row(query_item(-32'sh100000, 32'h200000), 1'b0, none));
        dir.push_back(row(query_item(32'h40000, 32'h80000), 1'b0, none));
        dir.push_back(row(query_item(32'h80000, 32'h300000), 1'b0, none));
        // unsorted pair: second point below the first
        dir.push_back(row(load_item(1, -32'sh100000, 32'h50000, SMAX, 7), 1'b0, none));
        dir.push_back(row(query_item(-32'sh200000, 32'h200000), 1'b0, none));
        dir.push_back(row(query_item(-32'sh80000, 32'h80000), 1'b0, none));
        dir.push_back(row(query_item(1, 2), 1'b0, none));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[i])
            send_item(dir[i].it, dir[i].typed, dir[i].want);

        // fill every slot before the point count grows
        load_profile(DEPTH);

        phase = 0;
        while (n_sent < ITEM_GOAL)
        begin
            if (phase < 6)
                n = pick_list[phase];
            else if ($urandom_range(9) == 0)
                n = $urandom_range(127);
            else
                n = $urandom_range(10, 2);
            phase++;
            set_points(n);
            neff = n < 2 ? 2 : (n > DEPTH ? DEPTH : n);
            load_profile(neff);
            ops = neff > 16 ? 6 : $urandom_range(30, 10);
            repeat (ops)
            begin
                case ($urandom_range(9))
                    0, 1:
                        send_item(load_item($urandom_range(63), $signed($urandom),
                                            $signed($urandom), $signed($urandom),
                                            $signed($urandom)), 1'b0, none);
                    2:
                    begin
                        lo = $signed($urandom);
                        hi = $signed($urandom);
                        send_item(query_item(lo, hi), 1'b0, none);
                    end
                    3:
                    begin
                        lo = near_point(neff);
                        send_item(query_item(lo, lo - $urandom_range(3)), 1'b0, none);
                    end
                    default:
                    begin
                        lo = near_point(neff);
                        hi = near_point(neff);
                        if (hi < lo)
                        begin
                            hi = lo + hi;
                            lo = hi - lo;
                            hi = hi - lo;
                        end
                        if (hi == lo) hi = clamp32(lo + 1);
                        send_item(query_item(lo, hi), 1'b0, none);
                    end
                endcase
            end
        end

        drain();
        $display("covered %0d loads, %0d queries (%0d empty or inverted), %0d point-count writes",
                 n_loads, n_queries, n_empty, n_cfg);
        $display("results checked: %0d, receiver hold-off applied: %0d", n_results, held_off);
        if (mismatches == 0 && averages_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
